@@ design/scfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types and constants for the sum-checked frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int FRAME_BYTES_DEF = 11;
    localparam int CFG_IDX_W       = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE = CFG_IDX_W'(1);

    // register reset values
    localparam logic [BYTE_W-1:0] FRAME_TYPE_RST   = 8'h53;
    localparam logic [BYTE_W-1:0] HEADER_VALUE_RST = 8'h55;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_COLLECT,
        ST_EMIT
    } t_state;

endpackage

@@ design/scfr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_cell
// One byte cell of the frame chain: loads its input when the chain shifts.
// ----------------------------------------------------------------------------
module scfr_cell
    import scfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [BYTE_W-1:0] i_d,
    output logic [BYTE_W-1:0] o_q
);

    logic [BYTE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_d;
        end
    end

    assign o_q = r_data;

endmodule

@@ design/sum_checked_frame_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver
// Hunts for a frame-type byte, collects a fixed-length frame and forwards it
// only when its 8-bit wrapped sum matches the trailing checksum byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_rx_byte) takes one received byte per
//   beat. While hunting or collecting a byte is taken every cycle.
//   Bytes travel down a chain of FRAME_BYTES byte cells; a running sum is kept
//   as they arrive, so the checksum is known on the frame's last byte.
//   On a match, slot 0 is loaded with header_value and the chain drains out of
//   its head: FRAME_BYTES output beats (o_valid / i_stall / o_frame_byte /
//   o_frame_last), the first one the cycle after the last input byte, and
//   o_frame_last on the checksum byte. A mismatch drops the frame silently.
//   While the frame drains o_stall is high; a stall on the output holds the
//   chain and the current beat. A full frame is FRAME_BYTES-1 input bytes
//   in and FRAME_BYTES output beats out.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready) writes frame_type
//   at index 0 and header_value at index 1; other indexes are ignored.
//   Synchronous reset returns to hunting with frame_type 0x53 and header 0x55.
// ----------------------------------------------------------------------------
module sum_checked_frame_receiver
    import scfr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input byte channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    // frame output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_W-1:0]    o_frame_byte,
    output logic                 o_frame_last,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    localparam int SLOT_W = $clog2(FRAME_BYTES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAME_BYTES - 1);

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_frame_type;
    logic [BYTE_W-1:0] r_header;

    logic              w_in_beat;
    logic              w_out_beat;
    logic              w_slot_last;
    logic              w_start;
    logic              w_match;
    logic              w_load_head;
    logic              w_shift;
    logic [BYTE_W-1:0] w_check;
    logic [BYTE_W-1:0] w_q [FRAME_BYTES];
    logic [BYTE_W-1:0] w_d [FRAME_BYTES];

    assign w_in_beat   = i_valid && !o_stall;
    assign w_out_beat  = o_valid && !i_stall;
    assign w_slot_last = (r_slot == SLOT_LAST);
    assign w_start     = (i_rx_byte == r_frame_type);
    assign w_check     = r_header + r_sum;
    assign w_match     = (w_check == i_rx_byte);

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_type <= FRAME_TYPE_RST;
            r_header     <= HEADER_VALUE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_FRAME_TYPE) begin
                r_frame_type <= i_cfg_data;
            end else if (i_cfg_index == REG_HEADER_VALUE) begin
                r_header <= i_cfg_data;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_HUNT: begin
                if (w_in_beat && w_start) begin
                    n_state = ST_COLLECT;
                end
            end
            ST_COLLECT: begin
                if (w_in_beat && w_slot_last) begin
                    n_state = w_match ? ST_EMIT : ST_HUNT;
                end
            end
            ST_EMIT: begin
                if (w_out_beat && w_slot_last) begin
                    n_state = ST_HUNT;
                end
            end
            default: n_state = ST_HUNT;
        endcase
    end

    // outputs and chain control
    always_comb begin
        o_stall     = 1'b0;
        o_valid     = 1'b0;
        w_shift     = 1'b0;
        w_load_head = 1'b0;
        unique case (r_state)
            ST_HUNT: begin
                w_shift = w_in_beat && w_start;
            end
            ST_COLLECT: begin
                w_shift     = w_in_beat;
                w_load_head = w_in_beat && w_slot_last && w_match;
            end
            ST_EMIT: begin
                o_stall = 1'b1;
                o_valid = 1'b1;
                w_shift = w_out_beat;
            end
            default: begin
                o_stall = 1'b0;
            end
        endcase
    end

    assign o_frame_byte = w_q[0];
    assign o_frame_last = o_valid && w_slot_last;

    // slot counter and running sum
    always_comb begin
        n_slot = r_slot;
        n_sum  = r_sum;
        unique case (r_state)
            ST_HUNT: begin
                if (w_in_beat && w_start) begin
                    n_slot = SLOT_W'(2);
                    n_sum  = i_rx_byte;
                end
            end
            ST_COLLECT: begin
                if (w_in_beat) begin
                    if (w_slot_last) begin
                        // drain count restarts at slot 0 on a match
                        n_slot = w_match ? SLOT_W'(0) : SLOT_W'(1);
                    end else begin
                        n_slot = r_slot + SLOT_W'(1);
                        n_sum  = r_sum + i_rx_byte;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_beat) begin
                    n_slot = w_slot_last ? SLOT_W'(1) : r_slot + SLOT_W'(1);
                end
            end
            default: n_slot = SLOT_W'(1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_slot  <= SLOT_W'(1);
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // byte chain: enter at the tail, leave at the head
    genvar g;
    generate
        for (g = 0; g < FRAME_BYTES; g++) begin : g_cell
            if (g == FRAME_BYTES - 1) begin : g_tail
                assign w_d[g] = i_rx_byte;
            end else if (g == 0) begin : g_head
                assign w_d[g] = w_load_head ? r_header : w_q[1];
            end else begin : g_mid
                assign w_d[g] = w_q[g+1];
            end

            scfr_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_d     (w_d[g]),
                .o_q     (w_q[g])
            );
        end
    endgenerate

    // no input beat is taken while a frame drains
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted during frame output");

    // a frame only starts draining right after an accepted input byte
    a_emit_after_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall))
        else $error("frame output without a preceding input byte");

    // the checksum beat ends the frame
    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_beat && o_frame_last) |=> !o_valid)
        else $error("output continues after the last beat");

    // frame beats stay contiguous until the last one
    a_frame_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_beat && !o_frame_last) |=> o_valid)
        else $error("frame output broken before the last beat");

endmodule
